// ===== rtl/fpso_pkg.sv =====
package fpso_pkg;

    localparam int MAX_DIM = 1024;
    // width of a frame size once capped at MAX_DIM
    localparam int DIM_W   = $clog2(MAX_DIM + 1);
    // signed width for the box geometry (frame size, offsets and pixel position)
    localparam int GEO_W   = DIM_W + 2;

    localparam logic [15:0] GLYPH_COLOR = 16'h07E0;
    localparam logic [15:0] HALF_MASK   = 16'h7BEF;

    localparam int NUM_DIGITS = 3;

    typedef enum logic [1:0] {
        CFG_OVERLAY_ENABLE = 2'd0,
        CFG_FRAME_WIDTH    = 2'd1,
        CFG_FRAME_HEIGHT   = 2'd2,
        CFG_WINDOW_LENGTH  = 2'd3
    } cfg_index_t;

    // low three decimal digits of the shown rate and how many of them are drawn
    typedef struct packed {
        logic [1:0]                  nd;
        logic [NUM_DIGITS-1:0][3:0]  digits;
    } rate_disp_t;

    // 3x5 digit glyphs, bit 2 is the left column
    localparam logic [2:0] GLYPH_ROWS [0:9][0:4] = '{
        '{3'h7, 3'h5, 3'h5, 3'h5, 3'h7},
        '{3'h2, 3'h6, 3'h2, 3'h2, 3'h7},
        '{3'h7, 3'h1, 3'h7, 3'h4, 3'h7},
        '{3'h7, 3'h1, 3'h7, 3'h1, 3'h7},
        '{3'h5, 3'h5, 3'h7, 3'h1, 3'h1},
        '{3'h7, 3'h4, 3'h7, 3'h1, 3'h7},
        '{3'h7, 3'h4, 3'h7, 3'h5, 3'h7},
        '{3'h7, 3'h1, 3'h2, 3'h2, 3'h2},
        '{3'h7, 3'h5, 3'h7, 3'h5, 3'h7},
        '{3'h7, 3'h5, 3'h7, 3'h1, 3'h7}
    };

    function automatic logic glyph_bit(input logic [3:0] digit, input logic [2:0] row,
                                       input logic [1:0] col);
        logic [2:0] line;
        logic [1:0] bit_sel;
        line    = 3'h0;
        bit_sel = 2'd2 - col;
        if (digit <= 4'd9 && row <= 3'd4) begin
            line = GLYPH_ROWS[digit][row];
        end
        return (col <= 2'd2) ? line[bit_sel] : 1'b0;
    endfunction

endpackage

// ===== rtl/fpso_tally.sv =====
module fpso_tally (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                frame_evt,
    input  logic [31:0]         now_us,
    input  logic [23:0]         window_length,
    output fpso_pkg::rate_disp_t disp,
    output logic [15:0]         rate_after
);

    logic [15:0] tally_reg, tally_next;
    logic [11:0] tally_bcd_reg, tally_bcd_next;
    logic [15:0] rate_reg, rate_next;
    logic [11:0] rate_bcd_reg, rate_bcd_next;
    logic [31:0] start_reg, start_next;

    logic [15:0] tally_inc;
    logic [11:0] tally_bcd_inc;
    logic [31:0] elapsed;
    logic        window_done;

    function automatic logic [11:0] bcd_inc(input logic [11:0] v);
        logic [3:0] d0, d1, d2;
        d0 = v[3:0];
        d1 = v[7:4];
        d2 = v[11:8];
        if (d0 == 4'd9) begin
            d0 = 4'd0;
            if (d1 == 4'd9) begin
                d1 = 4'd0;
                d2 = (d2 == 4'd9) ? 4'd0 : d2 + 4'd1;
            end else begin
                d1 = d1 + 4'd1;
            end
        end else begin
            d0 = d0 + 4'd1;
        end
        return {d2, d1, d0};
    endfunction

    // decimal copy follows the binary tally and stops with it at saturation
    always_comb begin
        tally_inc     = tally_reg;
        tally_bcd_inc = tally_bcd_reg;
        if (tally_reg != 16'hFFFF) begin
            tally_inc     = tally_reg + 16'd1;
            tally_bcd_inc = bcd_inc(tally_bcd_reg);
        end
    end

    assign elapsed     = now_us - start_reg;
    assign window_done = elapsed >= {8'd0, window_length};

    always_comb begin
        tally_next     = tally_reg;
        tally_bcd_next = tally_bcd_reg;
        rate_next      = rate_reg;
        rate_bcd_next  = rate_bcd_reg;
        start_next     = start_reg;
        if (frame_evt) begin
            if (window_done) begin
                rate_next      = tally_inc;
                rate_bcd_next  = tally_bcd_inc;
                tally_next     = 16'd0;
                tally_bcd_next = 12'd0;
                start_next     = now_us;
            end else begin
                tally_next     = tally_inc;
                tally_bcd_next = tally_bcd_inc;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tally_reg     <= 16'd0;
            tally_bcd_reg <= 12'd0;
            rate_reg      <= 16'd0;
            rate_bcd_reg  <= 12'd0;
            start_reg     <= 32'd0;
        end else begin
            tally_reg     <= tally_next;
            tally_bcd_reg <= tally_bcd_next;
            rate_reg      <= rate_next;
            rate_bcd_reg  <= rate_bcd_next;
            start_reg     <= start_next;
        end
    end

    assign rate_after = rate_next;

    always_comb begin
        disp.digits = rate_bcd_reg;
        if (rate_reg < 16'd10) begin
            disp.nd = 2'd1;
        end else if (rate_reg < 16'd100) begin
            disp.nd = 2'd2;
        end else begin
            disp.nd = 2'd3;
        end
    end

    a_bcd_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        rate_bcd_reg[3:0] <= 4'd9 && rate_bcd_reg[7:4] <= 4'd9 && rate_bcd_reg[11:8] <= 4'd9)
        else $error("shown rate holds a non-decimal digit");

    a_bcd_match: assert property (@(posedge aclk) disable iff (!aresetn)
        rate_reg < 16'd10 |-> rate_bcd_reg == {8'd0, rate_reg[3:0]})
        else $error("decimal copy of the rate disagrees with the binary value");

    a_window_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        frame_evt && window_done |=> tally_reg == 16'd0 && tally_bcd_reg == 12'd0
                                     && start_reg == $past(now_us))
        else $error("window close did not restart the tally");

endmodule

// ===== rtl/fpso_overlay.sv =====
module fpso_overlay (
    input  logic                          overlay_enable,
    input  logic [fpso_pkg::DIM_W-1:0]    width_cap,
    input  logic [fpso_pkg::DIM_W-1:0]    height_cap,
    input  logic [9:0]                    pos_x,
    input  logic [9:0]                    pos_y,
    input  logic [15:0]                   pixel_in,
    input  fpso_pkg::rate_disp_t          disp,
    output logic [15:0]                   pixel_out
);

    localparam int GW = fpso_pkg::GEO_W;

    logic signed [GW-1:0] w_s, x_s, box_w, box_left, box_right, col_base;
    logic signed [GW-1:0] col [fpso_pkg::NUM_DIGITS];
    logic [9:0]           row_full;
    logic [2:0]           row;
    logic                 in_box, in_rows, glyph_hit;

    assign w_s       = $signed(GW'(width_cap));
    assign x_s       = $signed(GW'(pos_x));
    assign box_w     = $signed(GW'({disp.nd, 2'b10}));
    assign box_left  = w_s - box_w - GW'(2);
    assign box_right = w_s - GW'(2);

    // box spans rows 2..8, clipped to the frame
    assign in_box = pos_y >= 10'd2 && pos_y < 10'd9 && {1'b0, pos_y} < height_cap
                    && x_s >= box_left && x_s < box_right;

    assign row_full = pos_y - 10'd3;
    assign row      = row_full[2:0];
    assign in_rows  = pos_y >= 10'd3 && pos_y < 10'd8;

    // ones digit starts at column w-6, each higher digit four columns further left
    assign col_base = x_s + GW'(6) - w_s;

    always_comb begin
        glyph_hit = 1'b0;
        for (int i = 0; i < fpso_pkg::NUM_DIGITS; i++) begin
            col[i] = col_base + GW'(4 * i);
            if (in_rows && col[i] >= 0 && col[i] < GW'(3) && GW'(i) < GW'(disp.nd)
                && fpso_pkg::glyph_bit(disp.digits[i], row, col[i][1:0])) begin
                glyph_hit = 1'b1;
            end
        end
    end

    always_comb begin
        pixel_out = pixel_in;
        if (overlay_enable && in_box) begin
            pixel_out = glyph_hit ? fpso_pkg::GLYPH_COLOR
                                  : ((pixel_in >> 1) & fpso_pkg::HALF_MASK);
        end
    end

endmodule

// ===== rtl/fps_counter_pixel_overlay.sv =====
// channel  | ports                                         | direction
// ---------+-----------------------------------------------+----------
// input    | s_valid s_ready s_func s_pos_x s_pos_y        | in
//          | s_pixel_in s_now_us                           |
// result   | m_valid m_ready m_pixel_out m_rate_shown      | out
// config   | cfg_valid cfg_ready cfg_index cfg_data        | in
//
// one word accepted per cycle while the result side is not stalled; it passes the input
// register, then the result register, with the single compute stage between them
// reset: synchronous active-low aresetn, tally, rate and window start cleared
// a stalled result holds the result register; the input register still takes
// a word while it is empty or the result register is free or draining that cycle
// cfg_ready is always high; writes land in the cycle they are accepted
module fps_counter_pixel_overlay (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_func,
    input  logic [9:0]  s_pos_x,
    input  logic [9:0]  s_pos_y,
    input  logic [15:0] s_pixel_in,
    input  logic [31:0] s_now_us,

    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_pixel_out,
    output logic [15:0] m_rate_shown,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [23:0] cfg_data
);

    localparam int DW = fpso_pkg::DIM_W;

    // configuration registers
    logic          overlay_enable_reg;
    logic [10:0]   frame_width_reg;
    logic [10:0]   frame_height_reg;
    logic [23:0]   window_length_reg;
    logic [DW-1:0] width_cap, height_cap;

    // input register
    logic          s1_valid_reg;
    logic          s1_func_reg;
    logic [9:0]    s1_pos_x_reg;
    logic [9:0]    s1_pos_y_reg;
    logic [15:0]   s1_pixel_reg;
    logic [31:0]   s1_now_reg;

    // result register
    logic          m_valid_reg;
    logic [15:0]   m_pixel_reg;
    logic [15:0]   m_rate_reg;

    logic                 advance;
    logic                 frame_evt;
    logic [15:0]          rate_after;
    logic [15:0]          overlay_px;
    fpso_pkg::rate_disp_t disp;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            overlay_enable_reg <= 1'b0;
            frame_width_reg    <= 11'd320;
            frame_height_reg   <= 11'd240;
            window_length_reg  <= 24'd1000000;
        end else if (cfg_valid) begin
            unique case (fpso_pkg::cfg_index_t'(cfg_index))
                fpso_pkg::CFG_OVERLAY_ENABLE: overlay_enable_reg <= cfg_data[0];
                fpso_pkg::CFG_FRAME_WIDTH:    frame_width_reg    <= cfg_data[10:0];
                fpso_pkg::CFG_FRAME_HEIGHT:   frame_height_reg   <= cfg_data[10:0];
                fpso_pkg::CFG_WINDOW_LENGTH:  window_length_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // sizes above the largest supported frame act as that frame
    assign width_cap  = (DW'(frame_width_reg) > DW'(fpso_pkg::MAX_DIM))
                        ? DW'(fpso_pkg::MAX_DIM) : DW'(frame_width_reg);
    assign height_cap = (DW'(frame_height_reg) > DW'(fpso_pkg::MAX_DIM))
                        ? DW'(fpso_pkg::MAX_DIM) : DW'(frame_height_reg);

    // word moves from the input register to the result register
    assign advance   = s1_valid_reg && (!m_valid_reg || m_ready);
    assign s_ready   = !s1_valid_reg || advance;
    assign frame_evt = advance && s1_func_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_ready) begin
            s1_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            s1_func_reg  <= s_func;
            s1_pos_x_reg <= s_pos_x;
            s1_pos_y_reg <= s_pos_y;
            s1_pixel_reg <= s_pixel_in;
            s1_now_reg   <= s_now_us;
        end
    end

    fpso_tally u_tally (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .frame_evt     (frame_evt),
        .now_us        (s1_now_reg),
        .window_length (window_length_reg),
        .disp          (disp),
        .rate_after    (rate_after)
    );

    fpso_overlay u_overlay (
        .overlay_enable (overlay_enable_reg),
        .width_cap      (width_cap),
        .height_cap     (height_cap),
        .pos_x          (s1_pos_x_reg),
        .pos_y          (s1_pos_y_reg),
        .pixel_in       (s1_pixel_reg),
        .disp           (disp),
        .pixel_out      (overlay_px)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // frame events carry a zero pixel
    always_ff @(posedge aclk) begin
        if (advance) begin
            m_pixel_reg <= s1_func_reg ? 16'd0 : overlay_px;
            m_rate_reg  <= rate_after;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_pixel_out  = m_pixel_reg;
    assign m_rate_shown = m_rate_reg;

    a_stage_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s1_valid_reg && !advance |=> s1_valid_reg && $stable(s1_now_reg)
                                     && $stable(s1_func_reg))
        else $error("input register lost a stalled word");

    a_result_source: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid_reg ##1 m_valid_reg |-> $past(advance))
        else $error("result register filled without a word moving");

    // a held result carries the rate after the last word that moved
    a_rate_steady: assert property (@(posedge aclk) disable iff (!aresetn)
        advance && !s1_func_reg && m_valid_reg |-> rate_after == m_rate_reg)
        else $error("pixel word changed the shown rate");

endmodule
